/* sv/xsed_pkg.sv */
// package with shared types, codes and helpers for the xref stream entry decoder
`timescale 1ns / 1ps

package xsed_pkg;

    localparam logic [3:0]  MAX_COL_BYTES = 4'd8;
    localparam logic [63:0] DEFAULT_TYPE  = 64'd1;
    localparam logic [63:0] TYPE_IN_USE   = 64'd1;
    localparam logic [63:0] TYPE_PACKED   = 64'd2;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_END    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ENTRY      = 2'd0,
        ST_END_OK     = 2'd1,
        ST_TRUNCATED  = 2'd2,
        ST_ZERO_WIDTH = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_FREE       = 2'd0,
        KIND_IN_USE     = 2'd1,
        KIND_COMPRESSED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_TYPE_WIDTH   = 2'd0,
        REG_FIRST_WIDTH  = 2'd1,
        REG_SECOND_WIDTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [3:0] type_width;
        logic [3:0] first_width;
        logic [3:0] second_width;
    } widths_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        kind_t       kind;
        logic [31:0] object_number;
        logic [63:0] offset_or_link;
        logic [31:0] generation_or_index;
    } result_t;

    function automatic logic [3:0] clamp_width(input logic [3:0] w);
        clamp_width = (w > MAX_COL_BYTES) ? MAX_COL_BYTES : w;
    endfunction

endpackage

/* sv/xsed_core.sv */
// entry state, byte routing and entry decode for one beat
`timescale 1ns / 1ps

module xsed_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [1:0]           command,
    input  logic [7:0]           data_byte,
    input  logic [31:0]          first_object,
    input  logic [31:0]          entry_count,
    input  xsed_pkg::widths_t    widths,
    output xsed_pkg::result_t    result
);

    logic [63:0] type_acc_reg,   type_acc_next;
    logic [63:0] first_acc_reg,  first_acc_next;
    logic [31:0] second_acc_reg, second_acc_next;
    logic [4:0]  byte_pos_reg,   byte_pos_next;
    logic [31:0] next_object_reg, next_object_next;
    logic [31:0] entries_left_reg, entries_left_next;

    logic [3:0]  tw;
    logic [3:0]  fw;
    logic [3:0]  sw;
    logic [4:0]  tf_end;
    logic [4:0]  total;
    logic [4:0]  pos_inc;
    logic [63:0] type_sh;
    logic [63:0] first_sh;
    logic [31:0] second_sh;
    logic [63:0] type_code;

    assign tw      = xsed_pkg::clamp_width(widths.type_width);
    assign fw      = xsed_pkg::clamp_width(widths.first_width);
    assign sw      = xsed_pkg::clamp_width(widths.second_width);
    assign tf_end  = {1'b0, tw} + {1'b0, fw};
    assign total   = tf_end + {1'b0, sw};
    assign pos_inc = byte_pos_reg + 5'd1;

    // route the byte into the column picked by the current position
    always_comb
    begin
        type_sh   = type_acc_reg;
        first_sh  = first_acc_reg;
        second_sh = second_acc_reg;
        if (byte_pos_reg < {1'b0, tw})
        begin
            type_sh = {type_acc_reg[55:0], data_byte};
        end
        else if (byte_pos_reg < tf_end)
        begin
            first_sh = {first_acc_reg[55:0], data_byte};
        end
        else
        begin
            second_sh = {second_acc_reg[23:0], data_byte};
        end
    end

    assign type_code = (tw == 4'd0) ? xsed_pkg::DEFAULT_TYPE : type_sh;

    always_comb
    begin
        type_acc_next     = type_acc_reg;
        first_acc_next    = first_acc_reg;
        second_acc_next   = second_acc_reg;
        byte_pos_next     = byte_pos_reg;
        next_object_next  = next_object_reg;
        entries_left_next = entries_left_reg;
        result            = '0;

        case (command)
            xsed_pkg::CMD_HEADER:
            begin
                type_acc_next   = '0;
                first_acc_next  = '0;
                second_acc_next = '0;
                byte_pos_next   = '0;
                if (total == 5'd0)
                begin
                    entries_left_next = '0;
                    result.valid      = 1'b1;
                    result.status     = xsed_pkg::ST_ZERO_WIDTH;
                end
                else
                begin
                    next_object_next  = first_object;
                    entries_left_next = entry_count;
                end
            end
            xsed_pkg::CMD_END:
            begin
                type_acc_next     = '0;
                first_acc_next    = '0;
                second_acc_next   = '0;
                byte_pos_next     = '0;
                entries_left_next = '0;
                result.valid      = 1'b1;
                if (total == 5'd0)
                    result.status = xsed_pkg::ST_ZERO_WIDTH;
                else if (entries_left_reg != 32'd0)
                    result.status = xsed_pkg::ST_TRUNCATED;
                else
                    result.status = xsed_pkg::ST_END_OK;
            end
            xsed_pkg::CMD_DATA:
            begin
                if (entries_left_reg != 32'd0 && total != 5'd0)
                begin
                    if (pos_inc < total)
                    begin
                        type_acc_next   = type_sh;
                        first_acc_next  = first_sh;
                        second_acc_next = second_sh;
                        byte_pos_next   = pos_inc;
                    end
                    else
                    begin
                        // last byte of the entry
                        result.valid         = 1'b1;
                        result.status        = xsed_pkg::ST_ENTRY;
                        result.object_number = next_object_reg;
                        if (type_code == xsed_pkg::TYPE_IN_USE)
                        begin
                            result.kind                = xsed_pkg::KIND_IN_USE;
                            result.offset_or_link      = first_sh;
                            result.generation_or_index = {16'd0, second_sh[15:0]};
                        end
                        else if (type_code == xsed_pkg::TYPE_PACKED)
                        begin
                            result.kind                = xsed_pkg::KIND_COMPRESSED;
                            result.offset_or_link      = {32'd0, first_sh[31:0]};
                            result.generation_or_index = second_sh;
                        end
                        else
                        begin
                            result.kind                = xsed_pkg::KIND_FREE;
                            result.offset_or_link      = {32'd0, first_sh[31:0]};
                            result.generation_or_index = {16'd0, second_sh[15:0]};
                        end
                        next_object_next  = next_object_reg + 32'd1;
                        entries_left_next = entries_left_reg - 32'd1;
                        type_acc_next     = '0;
                        first_acc_next    = '0;
                        second_acc_next   = '0;
                        byte_pos_next     = '0;
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_acc_reg     <= '0;
            first_acc_reg    <= '0;
            second_acc_reg   <= '0;
            byte_pos_reg     <= '0;
            next_object_reg  <= '0;
            entries_left_reg <= '0;
        end
        else if (step)
        begin
            type_acc_reg     <= type_acc_next;
            first_acc_reg    <= first_acc_next;
            second_acc_reg   <= second_acc_next;
            byte_pos_reg     <= byte_pos_next;
            next_object_reg  <= next_object_next;
            entries_left_reg <= entries_left_next;
        end
    end

endmodule

/* sv/xref_stream_entry_decoder_core.sv */
// top level of the xref stream entry decoder: handshakes, config and result register
`timescale 1ns / 1ps

// Decodes packed cross-reference stream entries, one beat per cycle unless stalled.
// Item channel (item_valid/item_ready): command selects a subsection header
// (first_object, entry_count), a data byte (data_byte) or end of stream.
// Result channel (result_valid/result_ready): one beat per completed entry,
// per end of stream, and per header given while the total entry width is zero.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): column widths in
// bytes, index 0 type, 1 first, 2 second; other indexes are dropped. Write
// only while the decoder is empty. cfg_ready is always high.
// Throughput: one item per cycle unless the result channel stalls, set by the
// single decode stage between the input register and the result register.
// An item beat reaches the ports through the input register and the result register.
// A stalled receiver holds the result register; the input register then
// fills and item_ready drops until the result beat goes out.
// Reset clears the entry state and the valid flags and loads the default
// widths 1, 4 and 2.
module xref_stream_entry_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic [31:0] first_object,
    input  logic [31:0] entry_count,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  status,
    output logic [1:0]  entry_kind,
    output logic [31:0] object_number,
    output logic [63:0] offset_or_link,
    output logic [31:0] generation_or_index,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    xsed_pkg::widths_t widths_reg;

    logic        in_valid_reg;
    logic [1:0]  command_reg;
    logic [7:0]  data_byte_reg;
    logic [31:0] first_object_reg;
    logic [31:0] entry_count_reg;

    xsed_pkg::result_t core_result;
    xsed_pkg::result_t result_reg;

    logic advance;

    assign cfg_ready  = 1'b1;
    assign advance    = in_valid_reg && (!result_reg.valid || result_ready);
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            widths_reg.type_width   <= 4'd1;
            widths_reg.first_width  <= 4'd4;
            widths_reg.second_width <= 4'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                xsed_pkg::REG_TYPE_WIDTH:   widths_reg.type_width   <= cfg_data;
                xsed_pkg::REG_FIRST_WIDTH:  widths_reg.first_width  <= cfg_data;
                xsed_pkg::REG_SECOND_WIDTH: widths_reg.second_width <= cfg_data;
                default:                    widths_reg              <= widths_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            command_reg      <= command;
            data_byte_reg    <= data_byte;
            first_object_reg <= first_object;
            entry_count_reg  <= entry_count;
        end
    end

    xsed_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .command      (command_reg),
        .data_byte    (data_byte_reg),
        .first_object (first_object_reg),
        .entry_count  (entry_count_reg),
        .widths       (widths_reg),
        .result       (core_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (advance && core_result.valid)
        begin
            result_reg <= core_result;
        end
        else if (result_ready)
        begin
            result_reg.valid <= 1'b0;
        end
    end

    assign result_valid        = result_reg.valid;
    assign status              = result_reg.status;
    assign entry_kind          = result_reg.kind;
    assign object_number       = result_reg.object_number;
    assign offset_or_link      = result_reg.offset_or_link;
    assign generation_or_index = result_reg.generation_or_index;

endmodule
